// ----- sv/pre_pkg.sv -----
`timescale 1ns / 1ps
// pre_pkg: shared types and constants for the pixel rectangle engine.
// No dependencies; used by pre_front, pre_queue, pre_back and the top level.
package pre_pkg;

   localparam int FRAME_W      = 9;
   localparam int COORD_W      = 16;
   localparam int PIXEL_W      = 8;
   localparam int CSR_INDEX_W  = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(256);

   typedef enum logic [1:0] {
      KIND_QUERY = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_MERGE = 2'd2,
      KIND_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WALK,
      BK_DRAIN,
      BK_RESP
   } bk_state_type;

   typedef struct packed {
      req_kind_type        kind;
      logic                active;
      logic [FRAME_W-1:0]  x1;
      logic [FRAME_W-1:0]  x2;
      logic [FRAME_W-1:0]  y1;
      logic [FRAME_W-1:0]  y2;
      logic [PIXEL_W-1:0]  pix;
   } job_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } bk_status_type;

endpackage

// ----- sv/pixel_rectangle_engine_unit.sv -----
`timescale 1ns / 1ps
// Clipped rectangle fill / merge / query over an 8-bit frame buffer.
// An item of N clipped pixels is walked by the back walker, one pixel
// per cycle on the single read and single write port; an empty one skips the walk.
// A response passes BK_WALK, BK_DRAIN and BK_RESP before rsp_valid rises; an empty one only BK_RESP.
// After reset a clearing pass writes MAX_WIDTH * MAX_HEIGHT zero bytes, one a cycle,
// while req_stall stays high; frame registers reset to 256 x 256.
module pixel_rectangle_engine_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_type,
   input  logic signed [pre_pkg::COORD_W-1:0]     req_rect_x,
   input  logic signed [pre_pkg::COORD_W-1:0]     req_rect_y,
   input  logic signed [pre_pkg::COORD_W-1:0]     req_rect_w,
   input  logic signed [pre_pkg::COORD_W-1:0]     req_rect_h,
   input  logic [pre_pkg::PIXEL_W-1:0]            req_pixel_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pre_pkg::PIXEL_W-1:0]            rsp_or_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pre_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pre_pkg::FRAME_W-1:0]            csr_wdata
);

   logic [pre_pkg::FRAME_W-1:0] frame_width_ff, frame_width_in;
   logic [pre_pkg::FRAME_W-1:0] frame_height_ff, frame_height_in;
   logic [pre_pkg::FRAME_W-1:0] fw, fh;
   logic                        push, queue_full, job_pop, job_valid;
   pre_pkg::job_type            push_job, pop_job;
   pre_pkg::bk_status_type      bk_status;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == pre_pkg::CSR_FRAME_WIDTH)  frame_width_in  = csr_wdata;
         if (csr_index == pre_pkg::CSR_FRAME_HEIGHT) frame_height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= pre_pkg::FRAME_RESET;
         frame_height_ff <= pre_pkg::FRAME_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign fw = (32'(frame_width_ff) > MAX_WIDTH) ? pre_pkg::FRAME_W'(MAX_WIDTH) : frame_width_ff;
   assign fh = (32'(frame_height_ff) > MAX_HEIGHT) ?
               pre_pkg::FRAME_W'(MAX_HEIGHT) : frame_height_ff;

   pre_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_pixel_value (req_pixel_value),
      .fw              (fw),
      .fh              (fh),
      .queue_full      (queue_full),
      .bk_status       (bk_status),
      .push            (push),
      .push_job        (push_job)
   );

   pre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_job   (pop_job),
      .not_empty (job_valid)
   );

   pre_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (pop_job),
      .job_pop      (job_pop),
      .fw           (fw),
      .bk_status    (bk_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_or_value (rsp_or_value)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && queue_full))
      else $error("request pushed into full queue");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      bk_status.clearing |-> !push)
      else $error("request accepted during clearing pass");

   a_idle_back_pops: assert property (@(posedge clock) disable iff (reset)
      (bk_status.idle && job_valid) |-> job_pop)
      else $error("idle back end left a queued request waiting");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> !bk_status.idle)
      else $error("back end stayed idle after taking a request");
`endif

endmodule

// ----- sv/pre_front.sv -----
`timescale 1ns / 1ps
// pre_front: accepts requests and clips the rectangle to the active frame.
// Depends on pre_pkg.
module pre_front (
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic signed [pre_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [pre_pkg::COORD_W-1:0] req_rect_y,
   input  logic signed [pre_pkg::COORD_W-1:0] req_rect_w,
   input  logic signed [pre_pkg::COORD_W-1:0] req_rect_h,
   input  logic [pre_pkg::PIXEL_W-1:0]        req_pixel_value,
   input  logic [pre_pkg::FRAME_W-1:0]        fw,
   input  logic [pre_pkg::FRAME_W-1:0]        fh,
   input  logic                               queue_full,
   input  pre_pkg::bk_status_type             bk_status,
   output logic                               push,
   output pre_pkg::job_type                   push_job
);

   logic signed [pre_pkg::COORD_W:0] x_end, y_end, fw_s, fh_s;
   logic signed [pre_pkg::COORD_W:0] x1_s, y1_s, x2_s, y2_s;
   pre_pkg::req_kind_type            kind;

   always_comb begin
      kind  = pre_pkg::req_kind_type'(req_type);
      x_end = 17'(req_rect_x) + 17'(req_rect_w);
      y_end = 17'(req_rect_y) + 17'(req_rect_h);
      fw_s  = signed'({8'b0, fw});
      fh_s  = signed'({8'b0, fh});
      x1_s  = req_rect_x[pre_pkg::COORD_W-1] ? '0 : 17'(req_rect_x);
      y1_s  = req_rect_y[pre_pkg::COORD_W-1] ? '0 : 17'(req_rect_y);
      x2_s  = (x_end < fw_s) ? x_end : fw_s;
      y2_s  = (y_end < fh_s) ? y_end : fh_s;

      push_job.kind   = kind;
      push_job.active = (kind != pre_pkg::KIND_NONE) && (x2_s > x1_s) && (y2_s > y1_s);
      push_job.x1     = x1_s[pre_pkg::FRAME_W-1:0];
      push_job.x2     = x2_s[pre_pkg::FRAME_W-1:0];
      push_job.y1     = y1_s[pre_pkg::FRAME_W-1:0];
      push_job.y2     = y2_s[pre_pkg::FRAME_W-1:0];
      push_job.pix    = req_pixel_value;
   end

   assign req_stall = queue_full || bk_status.clearing;
   assign push      = req_valid && !req_stall;

endmodule

// ----- sv/pre_queue.sv -----
`timescale 1ns / 1ps
// pre_queue: short request queue between the front and the back.
// Depends on pre_pkg.
module pre_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pre_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output pre_pkg::job_type pop_job,
   output logic             not_empty
);

   pre_pkg::job_type                     entry_ff [pre_pkg::QUEUE_DEPTH];
   logic [pre_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pre_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pre_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;

   function automatic logic [pre_pkg::QUEUE_CNT_W-1:0] QUEUE_ONE(input logic b);
      QUEUE_ONE = {{(pre_pkg::QUEUE_CNT_W-1){1'b0}}, b};
   endfunction

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_ONE(push) - QUEUE_ONE(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full      = (count_ff == pre_pkg::QUEUE_CNT_W'(pre_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

endmodule

// ----- sv/pre_back.sv -----
`timescale 1ns / 1ps
// pre_back: frame buffer memory, clearing pass and rectangle walker.
// Depends on pre_pkg.
module pre_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  pre_pkg::job_type            job,
   output logic                        job_pop,
   input  logic [pre_pkg::FRAME_W-1:0] fw,
   output pre_pkg::bk_status_type      bk_status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pre_pkg::PIXEL_W-1:0] rsp_or_value
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [pre_pkg::PIXEL_W-1:0] mem [DEPTH];

   pre_pkg::bk_state_type       state_ff, state_in;
   pre_pkg::job_type            job_ff, job_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [pre_pkg::FRAME_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [AW-1:0]               base_ff, base_in;
   logic                        pend_ff;
   logic [AW-1:0]               pend_addr_ff;
   logic [pre_pkg::PIXEL_W-1:0] rdata_ff;
   logic [pre_pkg::PIXEL_W-1:0] acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pre_pkg::PIXEL_W-1:0] rsp_value_ff, rsp_value_in;

   logic [AW-1:0]               cur_addr;
   logic                        last_col, last_row;
   logic                        mem_we, mem_re, rsp_load;
   logic [AW-1:0]               mem_waddr;
   logic [pre_pkg::PIXEL_W-1:0] mem_wdata;

   assign cur_addr = base_ff + AW'(col_ff);
   assign last_col = ({1'b0, col_ff} + 10'd1) == {1'b0, job_ff.x2};
   assign last_row = ({1'b0, row_ff} + 10'd1) == {1'b0, job_ff.y2};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pre_pkg::BK_CLEAR: begin
            if (clr_ff == LAST_ADDR) state_in = pre_pkg::BK_IDLE;
         end
         pre_pkg::BK_IDLE: begin
            if (job_valid) state_in = job.active ? pre_pkg::BK_WALK : pre_pkg::BK_RESP;
         end
         pre_pkg::BK_WALK: begin
            if (last_col && last_row) state_in = pre_pkg::BK_DRAIN;
         end
         pre_pkg::BK_DRAIN: state_in = pre_pkg::BK_RESP;
         pre_pkg::BK_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = pre_pkg::BK_IDLE;
         end
         default: state_in = pre_pkg::BK_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      job_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = job_ff.pix;
      rsp_load  = 1'b0;
      bk_status = '0;
      case (state_ff)
         pre_pkg::BK_CLEAR: begin
            bk_status.clearing = 1'b1;
            mem_we             = 1'b1;
            mem_waddr          = clr_ff;
            mem_wdata          = '0;
         end
         pre_pkg::BK_IDLE: begin
            bk_status.idle = 1'b1;
            job_pop        = job_valid;
         end
         pre_pkg::BK_WALK: begin
            mem_re = (job_ff.kind != pre_pkg::KIND_FILL);
            mem_we = (job_ff.kind == pre_pkg::KIND_FILL);
         end
         pre_pkg::BK_DRAIN: begin
         end
         pre_pkg::BK_RESP: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
      // read-modify-write of the previous pixel for merge
      if (pend_ff && job_ff.kind == pre_pkg::KIND_MERGE) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = rdata_ff | job_ff.pix;
      end
   end

   // datapath next values
   always_comb begin
      job_in       = job_ff;
      clr_in       = clr_ff + 1'b1;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      if (job_pop) begin
         job_in  = job;
         col_in  = job.x1;
         row_in  = job.y1;
         base_in = AW'(AW'(job.y1) * AW'(fw));
         acc_in  = '0;
      end else if (state_ff == pre_pkg::BK_WALK) begin
         if (last_col) begin
            col_in  = job_ff.x1;
            row_in  = row_ff + 1'b1;
            base_in = base_ff + AW'(fw);
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (pend_ff && job_ff.kind == pre_pkg::KIND_QUERY) begin
         acc_in = acc_ff | rdata_ff;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pre_pkg::BK_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= mem_re;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      pend_addr_ff <= cur_addr;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[cur_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_or_value = rsp_value_ff;

endmodule
